// ===== rtl/pfa_pkg.sv =====
// shared types and constants for the bitmap page frame allocator
// used by pfa_ctrl, pfa_dp and the top level; depends on nothing else
package pfa_pkg;

	localparam int MAX_FRAMES_DEF = 4096;
	localparam int PAGE_BYTES_DEF = 4096;

	localparam int ADDR_W    = 24;
	localparam int FCNT_W    = 13;
	localparam int KB_W      = 15;
	localparam int WORD_BITS = 32;
	localparam int KB_SHIFT  = 10;
	localparam int CMP_W     = 21;

	// m_tdata: alloc_address, used_kb, free_kb, padded to whole bytes
	localparam int OUT_RAW_W  = ADDR_W + 2 * KB_W;
	localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

	localparam logic [FCNT_W-1:0] FCNT_RESET = 13'd4096;
	localparam logic [KB_W-1:0]   KB_MAX     = 15'h7FFF;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_FRAME  = 2'd1,
		ST_NULL_FREE = 2'd2,
		ST_NOT_USED  = 2'd3
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic    load_req;
		logic    clr_wr;
		logic    scan_start;
		logic    scan_rd;
		logic    alloc_wr;
		logic    free_rd;
		logic    free_wr;
		logic    res_load;
		status_t res_status;
	} pfa_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_free;
		logic null_free;
		logic out_of_range;
		logic scan_more;
		logic rd_hit;
		logic bit_set;
		logic clr_last;
		logic out_busy;
	} pfa_sts_t;

endpackage

// ===== rtl/pfa_ctrl.sv =====
// controller state machine of the page frame allocator
// sequences clear pass, bitmap scan, alloc/free update and result hand-off; uses pfa_pkg
module pfa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  pfa_pkg::pfa_sts_t sts,
	output pfa_pkg::pfa_cmd_t cmd
);
	import pfa_pkg::*;

	typedef enum logic [6:0] {
		S_CLEAR    = 7'b0000001,
		S_IDLE     = 7'b0000010,
		S_DISPATCH = 7'b0000100,
		S_SCAN     = 7'b0001000,
		S_ALLOC_WR = 7'b0010000,
		S_FREE_CHK = 7'b0100000,
		S_DONE     = 7'b1000000
	} state_t;

	state_t  state_q, state_d;
	status_t status_q, status_d;

	always_comb begin
		state_d  = state_q;
		status_d = status_q;
		cmd      = '0;
		cmd.res_status = status_q;
		s_tready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_req = 1'b1;
					state_d      = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (sts.is_free) begin
					if (sts.null_free) begin
						status_d = ST_NULL_FREE;
						state_d  = S_DONE;
					end else if (sts.out_of_range) begin
						status_d = ST_NOT_USED;
						state_d  = S_DONE;
					end else begin
						cmd.free_rd = 1'b1;
						state_d     = S_FREE_CHK;
					end
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_SCAN: begin
				// read of word n+1 overlaps the check of word n
				if (sts.rd_hit) begin
					state_d = S_ALLOC_WR;
				end else if (!sts.scan_more) begin
					status_d = ST_NO_FRAME;
					state_d  = S_DONE;
				end else begin
					cmd.scan_rd = 1'b1;
				end
			end
			S_ALLOC_WR: begin
				cmd.alloc_wr = 1'b1;
				status_d     = ST_OK;
				state_d      = S_DONE;
			end
			S_FREE_CHK: begin
				if (sts.bit_set) begin
					cmd.free_wr = 1'b1;
					status_d    = ST_OK;
				end else begin
					status_d = ST_NOT_USED;
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			status_q <= ST_OK;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
		end
	end

endmodule

// ===== rtl/pfa_dp.sv =====
// datapath of the page frame allocator: bitmap memory, scan pointer, used counter,
// frame count register and output word register; uses pfa_pkg, driven by pfa_ctrl
module pfa_dp #(
	parameter int MAX_FRAMES = pfa_pkg::MAX_FRAMES_DEF,
	parameter int PAGE_BYTES = pfa_pkg::PAGE_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pfa_pkg::pfa_cmd_t                cmd,
	output pfa_pkg::pfa_sts_t                sts,
	input  logic [pfa_pkg::ADDR_W-1:0]       s_tdata,
	input  logic                             s_tuser,
	input  logic                             cfg_we,
	input  logic [pfa_pkg::FCNT_W-1:0]       cfg_wdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [pfa_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic [1:0]                       m_tuser
);
	import pfa_pkg::*;

	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int WORDS      = MAX_FRAMES / WORD_BITS;
	localparam int WAW        = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int PW         = $clog2(WORDS + 1);
	localparam int FIW        = WAW + 5;
	localparam int FAW        = ADDR_W - PAGE_SHIFT;
	localparam int CW         = $clog2(MAX_FRAMES + 1);
	localparam int MW         = (CW > FCNT_W) ? CW : FCNT_W;
	localparam int KW         = CW + PAGE_SHIFT;
	localparam int AW2        = FIW + PAGE_SHIFT;

	logic [WORD_BITS-1:0] mem [WORDS];

	logic [FCNT_W-1:0]    frame_count_q;
	logic [CW-1:0]        used_count_q;
	logic                 cmd_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [WAW-1:0]       clr_ptr_q;
	logic [PW-1:0]        ptr_q;
	logic [WAW-1:0]       rd_idx_q;
	logic                 rdv_q;
	logic [WORD_BITS-1:0] rd_data_q;
	logic [FIW-1:0]       frame_q;
	logic                 alloc_ok_q;
	logic                 m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [1:0]           m_tuser_q;

	logic [FAW-1:0]       free_frame;
	logic [CMP_W-1:0]     free_ext;
	logic [WAW-1:0]       free_word;
	logic [4:0]           free_bit;
	logic [MW-1:0]        managed;
	logic [MW-1:0]        avail;
	logic [4:0]           lz_bit;
	logic                 rd_en;
	logic [WAW-1:0]       rd_addr;
	logic                 wr_en;
	logic [WAW-1:0]       wr_addr;
	logic [WORD_BITS-1:0] wr_data;
	logic [AW2-1:0]       frame_bytes;
	logic [ADDR_W-1:0]    alloc_addr;

	function automatic logic [KB_W-1:0] to_kb(input logic [CW-1:0] n);
		logic [KW-1:0] b;
		logic [KW-1:0] k;
		b = KW'(n) << PAGE_SHIFT;
		k = b >> KB_SHIFT;
		if (k > KW'(KB_MAX)) return KB_MAX;
		else return KB_W'(k);
	endfunction

	assign free_frame = addr_q[ADDR_W-1:PAGE_SHIFT];
	assign free_ext   = CMP_W'(free_frame);
	assign free_word  = free_ext[FIW-1:5];
	assign free_bit   = free_ext[4:0];

	assign managed = (MW'(frame_count_q) > MW'(MAX_FRAMES)) ? MW'(MAX_FRAMES)
		: MW'(frame_count_q);
	assign avail   = (MW'(used_count_q) > managed) ? '0 : managed - MW'(used_count_q);

	// lowest clear bit of the word under check
	always_comb begin
		lz_bit = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!rd_data_q[i]) lz_bit = 5'(i);
		end
	end

	always_comb begin
		sts.is_free      = (cmd_q == CMD_FREE);
		sts.null_free    = (free_frame == '0);
		sts.out_of_range = (free_ext >= CMP_W'(MAX_FRAMES));
		sts.scan_more    = (CMP_W'(ptr_q) < CMP_W'(managed >> 5));
		sts.rd_hit       = rdv_q && (rd_data_q != '1);
		sts.bit_set      = rd_data_q[free_bit];
		sts.clr_last     = (clr_ptr_q == WAW'(WORDS - 1));
		sts.out_busy     = m_tvalid_q && !m_tready;
	end

	assign rd_en   = cmd.scan_rd || cmd.free_rd;
	assign rd_addr = cmd.scan_rd ? ptr_q[WAW-1:0] : free_word;
	assign wr_en   = cmd.clr_wr || cmd.alloc_wr || cmd.free_wr;

	always_comb begin
		wr_addr = clr_ptr_q;
		wr_data = '0;
		if (cmd.alloc_wr) begin
			wr_addr = rd_idx_q;
			wr_data = rd_data_q | (WORD_BITS'(1) << lz_bit);
		end else if (cmd.free_wr) begin
			wr_addr = free_word;
			wr_data = rd_data_q & ~(WORD_BITS'(1) << free_bit);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FCNT_RESET;
			used_count_q  <= '0;
			clr_ptr_q     <= '0;
			ptr_q         <= '0;
			rdv_q         <= 1'b0;
			alloc_ok_q    <= 1'b0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (cfg_we) frame_count_q <= cfg_wdata;
			if (cmd.clr_wr) clr_ptr_q <= clr_ptr_q + WAW'(1);
			if (cmd.scan_start) ptr_q <= '0;
			else if (cmd.scan_rd) ptr_q <= ptr_q + PW'(1);
			rdv_q <= cmd.scan_rd;
			if (cmd.load_req) alloc_ok_q <= 1'b0;
			else if (cmd.alloc_wr) alloc_ok_q <= 1'b1;
			if (cmd.alloc_wr) used_count_q <= used_count_q + CW'(1);
			else if (cmd.free_wr) used_count_q <= used_count_q - CW'(1);
			if (cmd.res_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			cmd_q  <= s_tuser;
			addr_q <= s_tdata;
		end
		if (cmd.scan_rd) rd_idx_q <= ptr_q[WAW-1:0];
		if (cmd.alloc_wr) frame_q <= {rd_idx_q, lz_bit};
	end

	assign frame_bytes = AW2'(frame_q) << PAGE_SHIFT;
	assign alloc_addr  = alloc_ok_q ? ADDR_W'(frame_bytes) : '0;

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			m_tdata_q <= OUT_DATA_W'({to_kb(CW'(avail)), to_kb(used_count_q), alloc_addr});
			m_tuser_q <= cmd.res_status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_count_q <= CW'(MAX_FRAMES))
		else $error("used frame count above bitmap size");

	a_alloc_free_word: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc_wr |-> (rd_data_q != '1))
		else $error("allocation into a full bitmap word");

	a_free_set_bit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.free_wr |-> (rd_data_q[free_bit] && used_count_q != '0))
		else $error("free of a frame that is not in use");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> !(m_tvalid_q && !m_tready))
		else $error("result word overwritten while stalled");

endmodule

// ===== rtl/bitmap_page_frame_allocator.sv =====
// Bitmap page frame allocator, first fit.
// Request channel s_*: s_tuser is the command (0 allocate one frame, 1 free),
// s_tdata is the byte address to free (ignored on allocate). Result channel m_*:
// m_tuser is the status (ok, no free frame, null free, frame not in use) and
// m_tdata packs alloc_address, used_kb and free_kb.
// The frame count register is written through cfg_we/cfg_wdata; the user must write it
// only while idle, as the block itself does not enforce this. An allocate reads up to
// W = min(frame_count, MAX_FRAMES) / 32 bitmap words one per cycle through the single read
// port of the bitmap memory and stops at the first word with a clear bit; a free reads the
// word of its frame and rewrites it if the frame is in use, a null or out-of-range free reads
// none. One request is in flight at a time, so the next request is accepted in the cycle after
// the result is loaded. After reset the bitmap memory is cleared one word per cycle, all
// MAX_FRAMES / 32 words (128 by default), and s_tready stays low until the pass is done.
// The result sits in an output register: a new request is accepted while it
// waits, and the block holds its next result until m_tready takes the old one.
module bitmap_page_frame_allocator #(
	parameter int MAX_FRAMES = pfa_pkg::MAX_FRAMES_DEF,
	parameter int PAGE_BYTES = pfa_pkg::PAGE_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [pfa_pkg::ADDR_W-1:0]     s_tdata,   // free_address[23:0]
	input  logic                           s_tuser,   // cmd
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [pfa_pkg::OUT_DATA_W-1:0] m_tdata,   // alloc_address[23:0], used_kb[38:24], free_kb[53:39]
	output logic [1:0]                     m_tuser,   // status
	input  logic                           cfg_we,
	input  logic [pfa_pkg::FCNT_W-1:0]     cfg_wdata
);
	import pfa_pkg::*;

	pfa_cmd_t cmd;
	pfa_sts_t sts;

	pfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pfa_dp #(
		.MAX_FRAMES (MAX_FRAMES),
		.PAGE_BYTES (PAGE_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
